### hdl/channel_mix_matrix_macros.svh
// ----------------------------------------------------------------------------
// Channel mix matrix assertion macros
// Shared property forms for the checker that watches the block's ports.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_MIX_MATRIX_MACROS_SVH
`define CHANNEL_MIX_MATRIX_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and muted during reset.
`define CMM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock and muted during reset.
`define CMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cmm_pkg.sv
// ----------------------------------------------------------------------------
// Channel mix matrix package
// Beat types, queue command type, sequencer states and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cmm_pkg;

   // Fixed field widths.
   localparam int IDX_W       = 3;
   localparam int IDX_COUNT   = 8;
   localparam int GAIN_W      = 24;
   localparam int SAMPLE_W    = 32;
   localparam int PROD_W      = SAMPLE_W + GAIN_W;
   localparam int COUNT_W     = 32;

   // Gain table geometry: one entry for every reachable index pair.
   localparam int GAIN_ADDR_W = 2 * IDX_W;
   localparam int GAIN_DEPTH  = IDX_COUNT * IDX_COUNT;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Register port.
   localparam int CFG_W       = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

   // Register indexes.
   localparam logic REG_IN_CHANNELS  = 1'b0;
   localparam logic REG_OUT_CHANNELS = 1'b1;

   // Action codes of an input beat.
   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   // Saturation bounds of a result.
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

   // Input beat.
   typedef struct packed {
      logic                       action;
      logic [IDX_W-1:0]           out_index;
      logic [IDX_W-1:0]           in_index;
      logic signed [GAIN_W-1:0]   gain;
      logic signed [SAMPLE_W-1:0] sample;
   } cmm_item_type;

   // Result beat.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_sample;
      logic [IDX_W-1:0]           out_channel;
      logic                       last_of_frame;
      logic                       clipped;
      logic [COUNT_W-1:0]         clip_total;
   } cmm_result_type;

   // Classified command held in the queue.
   typedef enum logic {
      CMD_LOAD,
      CMD_SAMPLE
   } cmm_kind_type;

   typedef struct packed {
      cmm_kind_type               kind;
      logic [IDX_W-1:0]           out_index;
      logic [IDX_W-1:0]           in_index;
      logic signed [GAIN_W-1:0]   gain;
      logic signed [SAMPLE_W-1:0] sample;
   } cmm_cmd_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MAC,
      BK_DRAIN,
      BK_ROUND,
      BK_EMIT
   } cmm_state_type;

endpackage

`default_nettype wire

### hdl/cmm_front.sv
// ----------------------------------------------------------------------------
// Channel mix matrix front end
// Accepts input beats, classifies them and drops loads whose indexes fall
// outside the channel maximums before they enter the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_front #(
   parameter int MAX_IN_CHANNELS  = 8,
   parameter int MAX_OUT_CHANNELS = 8
) (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cmm_pkg::cmm_item_type req_data,
   input  logic                  queue_full,
   output logic                  push,
   output cmm_pkg::cmm_cmd_type  cmd
);
   import cmm_pkg::*;

   logic keep;

   // The queue alone decides whether a beat can be taken.
   assign req_stall = queue_full;

   // Classify the beat: samples always go on, loads only with legal indexes.
   always_comb begin
      cmd.out_index = req_data.out_index;
      cmd.in_index  = req_data.in_index;
      cmd.gain      = req_data.gain;
      cmd.sample    = req_data.sample;
      unique case (req_data.action)
         ACTION_LOAD: begin
            cmd.kind = CMD_LOAD;
            keep     = (int'(req_data.out_index) < MAX_OUT_CHANNELS) &&
                       (int'(req_data.in_index) < MAX_IN_CHANNELS);
         end
         ACTION_SAMPLE: begin
            cmd.kind = CMD_SAMPLE;
            keep     = 1'b1;
         end
         default: begin
            cmd.kind = CMD_LOAD;
            keep     = 1'b0;
         end
      endcase
   end

   // A dropped load is still accepted, it just never reaches the queue.
   assign push = req_valid && !queue_full && keep;

endmodule

`default_nettype wire

### hdl/cmm_fifo.sv
// ----------------------------------------------------------------------------
// Channel mix matrix command queue
// Short first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cmm_pkg::cmm_cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output cmm_pkg::cmm_cmd_type head
);
   import cmm_pkg::*;

   cmm_cmd_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/cmm_back.sv
// ----------------------------------------------------------------------------
// Channel mix matrix back end
// Holds the gain table and the accumulators, runs one shared
// multiply-accumulate across the output channels for each sample, and
// rounds, clips and counts the results at the end of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_back #(
   parameter int MAX_IN_CHANNELS  = 8,
   parameter int MAX_OUT_CHANNELS = 8,
   parameter int GAIN_FRAC_BITS   = 20
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  cmm_pkg::cmm_cmd_type                        cmd,
   input  logic                                        cmd_valid,
   output logic                                        cmd_pop,
   input  logic                                        frame_clear,
   input  logic [$clog2(MAX_IN_CHANNELS+1)-1:0]        nin_eff,
   input  logic [$clog2(MAX_OUT_CHANNELS+1)-1:0]       nout_eff,
   input  logic                                        rsp_stall,
   output logic                                        rsp_valid,
   output cmm_pkg::cmm_result_type                     rsp_data
);
   import cmm_pkg::*;

   localparam int PNW     = $clog2(MAX_IN_CHANNELS + 1);
   localparam int NW      = $clog2(MAX_OUT_CHANNELS + 1);
   localparam int PW      = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
   localparam int JW      = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
   localparam int ACC_W   = PROD_W + $clog2(MAX_IN_CHANNELS);
   localparam int SHIFT_W = ACC_W - GAIN_FRAC_BITS;
   localparam int RW      = (SHIFT_W > SAMPLE_W + 1) ? SHIFT_W : SAMPLE_W + 1;
   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-1){1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);

   // Sequencer.
   cmm_state_type              state_ff;
   cmm_state_type              state_in;
   logic [JW-1:0]              j_ff;
   logic [JW-1:0]              j_in;
   logic [PW-1:0]              pos_ff;
   logic [PW-1:0]              pos_in;
   logic                       last_j;
   logic                       frame_last;
   logic                       out_free;
   logic                       issue;
   logic                       round_en;
   logic                       emit_en;
   logic                       acc_clear;
   logic                       pos_step;

   // Gain table.
   logic signed [GAIN_W-1:0]   gain_mem [GAIN_DEPTH];
   logic [GAIN_DEPTH-1:0]      gain_vld_ff;
   logic                       gain_wr;
   logic [GAIN_ADDR_W-1:0]     gain_wr_addr;
   logic [GAIN_ADDR_W-1:0]     gain_rd_addr;
   logic [JW+IDX_W-1:0]        j_wide;
   logic [PW+IDX_W-1:0]        pos_wide;
   logic                       rd_in_range;

   // Multiply-accumulate pipeline.
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       p1_vld_ff;
   logic [JW-1:0]              p1_j_ff;
   logic signed [GAIN_W-1:0]   gain_rd_ff;
   logic                       gain_ok_ff;
   logic signed [GAIN_W-1:0]   gain_eff;
   logic signed [PROD_W-1:0]   prod_in;
   logic                       p2_vld_ff;
   logic [JW-1:0]              p2_j_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff [MAX_OUT_CHANNELS];

   // Rounding and output.
   logic signed [ACC_W-1:0]    acc_sel;
   logic signed [ACC_W-1:0]    rnd_sum;
   logic signed [ACC_W-1:0]    rnd_shift;
   logic signed [RW-1:0]       rnd_in;
   logic signed [RW-1:0]       rnd_ff;
   logic [RW-SAMPLE_W:0]       rnd_hi;
   logic                       clip;
   logic [COUNT_W-1:0]         clip_cnt_ff;
   logic [COUNT_W-1:0]         clip_cnt_in;
   cmm_result_type             res_in;
   logic                       rsp_valid_ff;
   cmm_result_type             rsp_data_ff;

   assign last_j     = (NW'(j_ff) + NW'(1) == nout_eff);
   assign frame_last = (PNW'(pos_ff) + PNW'(1) >= nin_eff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && (cmd.kind == CMD_SAMPLE)) begin
               state_in = BK_MAC;
            end
         end
         BK_MAC: begin
            if (last_j) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!p1_vld_ff) begin
               state_in = frame_last ? BK_ROUND : BK_IDLE;
            end
         end
         BK_ROUND: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = last_j ? BK_IDLE : BK_ROUND;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      cmd_pop   = 1'b0;
      issue     = 1'b0;
      round_en  = 1'b0;
      emit_en   = 1'b0;
      acc_clear = 1'b0;
      pos_step  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid;
         end
         BK_MAC: begin
            issue = 1'b1;
         end
         BK_DRAIN: begin
            pos_step = !p1_vld_ff && !frame_last;
         end
         BK_ROUND: begin
            round_en = 1'b1;
         end
         BK_EMIT: begin
            emit_en   = out_free;
            acc_clear = out_free && last_j;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   // Output channel counter and frame position.
   always_comb begin
      j_in = j_ff;
      if (issue || emit_en) begin
         j_in = last_j ? '0 : j_ff + JW'(1);
      end
      pos_in = pos_ff;
      if (frame_clear || acc_clear) begin
         pos_in = '0;
      end else if (pos_step) begin
         pos_in = pos_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         j_ff     <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         pos_ff   <= pos_in;
      end
   end

   // Latch the sample of a popped sample command.
   always_ff @(posedge clock) begin
      if (cmd_pop && (cmd.kind == CMD_SAMPLE)) begin
         sample_ff <= cmd.sample;
      end
   end

   // Gain table addressing; pairs past the index range read as zero.
   assign gain_wr      = cmd_pop && (cmd.kind == CMD_LOAD);
   assign gain_wr_addr = {cmd.out_index, cmd.in_index};
   assign j_wide       = (JW+IDX_W)'(j_ff);
   assign pos_wide     = (PW+IDX_W)'(pos_ff);
   assign rd_in_range  = (j_wide < (JW+IDX_W)'(IDX_COUNT)) &&
                         (pos_wide < (PW+IDX_W)'(IDX_COUNT));
   assign gain_rd_addr = {j_wide[IDX_W-1:0], pos_wide[IDX_W-1:0]};

   // Gain memory with registered read.
   always_ff @(posedge clock) begin
      if (gain_wr) begin
         gain_mem[gain_wr_addr] <= cmd.gain;
      end
      gain_rd_ff <= gain_mem[gain_rd_addr];
   end

   // Entry valid bits; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_vld_ff <= '0;
         gain_ok_ff  <= 1'b0;
      end else begin
         if (gain_wr) begin
            gain_vld_ff[gain_wr_addr] <= 1'b1;
         end
         gain_ok_ff <= gain_vld_ff[gain_rd_addr] && rd_in_range;
      end
   end

   // Product stage.
   assign gain_eff = gain_ok_ff ? gain_rd_ff : '0;
   assign prod_in  = PROD_W'(sample_ff) * PROD_W'(gain_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= issue;
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_j_ff <= j_ff;
      p2_j_ff <= p1_j_ff;
      prod_ff <= prod_in;
   end

   // Accumulators, cleared on reset, on a register write and after a frame.
   always_ff @(posedge clock) begin
      if (reset || frame_clear || acc_clear) begin
         for (int k = 0; k < MAX_OUT_CHANNELS; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (p2_vld_ff) begin
         acc_ff[p2_j_ff] <= acc_ff[p2_j_ff] + ACC_W'(prod_ff);
      end
   end

   // Round half away from zero: add half, less one for a negative sum, then
   // shift arithmetically.
   assign acc_sel   = acc_ff[j_ff];
   assign rnd_sum   = acc_sel + HALF - {{(ACC_W-1){1'b0}}, acc_sel[ACC_W-1]};
   assign rnd_shift = rnd_sum >>> GAIN_FRAC_BITS;
   assign rnd_in    = RW'(rnd_shift);

   always_ff @(posedge clock) begin
      if (round_en) begin
         rnd_ff <= rnd_in;
      end
   end

   // Clip when the bits above the result are not a plain sign extension.
   assign rnd_hi = rnd_ff[RW-1:SAMPLE_W-1];
   assign clip   = !((&rnd_hi) || !(|rnd_hi));

   always_comb begin
      clip_cnt_in = clip_cnt_ff;
      if (clip && (clip_cnt_ff != '1)) begin
         clip_cnt_in = clip_cnt_ff + COUNT_W'(1);
      end
      res_in.mixed_sample  = clip ? (rnd_ff[RW-1] ? SAMPLE_MIN : SAMPLE_MAX)
                                  : rnd_ff[SAMPLE_W-1:0];
      res_in.out_channel   = IDX_W'(j_ff);
      res_in.last_of_frame = last_j;
      res_in.clipped       = clip;
      res_in.clip_total    = clip_cnt_in;
   end

   // Output register and clip counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clip_cnt_ff  <= '0;
      end else if (emit_en) begin
         rsp_valid_ff <= 1'b1;
         clip_cnt_ff  <= clip_cnt_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         rsp_data_ff <= res_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/channel_mix_matrix.sv
// ----------------------------------------------------------------------------
// Channel mix matrix
// Remixes interleaved audio frames through a table of signed gains.
// ----------------------------------------------------------------------------
// A load beat writes one gain table entry and gives no result. A sample beat
// goes through the single shared multiply-accumulate that visits every
// output channel in turn: the back end fetches the item, issues one product
// per output, then waits for the gain read and product stages to empty. The
// last sample of a frame then rounds each output channel and loads the
// result register, waiting whenever the result side stalls. A four-entry
// command queue keeps taking beats, until it is full, while the back end
// works or waits on a stalled result. The gain table needs no clearing pass:
// per-entry valid bits make it read as zero after reset. Register writes
// clear the accumulators and restart the frame at input channel zero.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_mix_matrix #(
   parameter int MAX_IN_CHANNELS  = 8,
   parameter int MAX_OUT_CHANNELS = 8,
   parameter int GAIN_FRAC_BITS   = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  cmm_pkg::cmm_item_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cmm_pkg::cmm_result_type               rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cmm_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [cmm_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [cmm_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import cmm_pkg::*;

   localparam int PNW = $clog2(MAX_IN_CHANNELS + 1);
   localparam int NW  = $clog2(MAX_OUT_CHANNELS + 1);

   logic [CFG_W-1:0] in_chan_ff;
   logic [CFG_W-1:0] out_chan_ff;
   logic             csr_wr;
   logic             csr_index;
   logic [PNW-1:0]   nin_eff;
   logic [NW-1:0]    nout_eff;
   logic             queue_full;
   logic             queue_push;
   logic             queue_pop;
   logic             queue_not_empty;
   cmm_cmd_type      push_cmd;
   cmm_cmd_type      head_cmd;

   // Register port: always ready, one write per access phase.
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_chan_ff  <= CFG_RESET;
         out_chan_ff <= CFG_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_IN_CHANNELS:  in_chan_ff  <= pwdata[CFG_W-1:0];
            REG_OUT_CHANNELS: out_chan_ff <= pwdata[CFG_W-1:0];
            default:          in_chan_ff  <= in_chan_ff;
         endcase
      end
   end

   // Read back.
   always_comb begin
      unique case (csr_index)
         REG_IN_CHANNELS:  prdata = CSR_DATA_W'(in_chan_ff);
         REG_OUT_CHANNELS: prdata = CSR_DATA_W'(out_chan_ff);
         default:          prdata = '0;
      endcase
   end

   // Channel counts in use: zero counts as one, large values are capped.
   always_comb begin
      if (in_chan_ff == '0) begin
         nin_eff = PNW'(1);
      end else if (int'(in_chan_ff) > MAX_IN_CHANNELS) begin
         nin_eff = PNW'(MAX_IN_CHANNELS);
      end else begin
         nin_eff = PNW'(in_chan_ff);
      end
      if (out_chan_ff == '0) begin
         nout_eff = NW'(1);
      end else if (int'(out_chan_ff) > MAX_OUT_CHANNELS) begin
         nout_eff = NW'(MAX_OUT_CHANNELS);
      end else begin
         nout_eff = NW'(out_chan_ff);
      end
   end

   // Front end: classify beats.
   cmm_front #(
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (queue_push),
      .cmd        (push_cmd)
   );

   // Command queue.
   cmm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (head_cmd)
   );

   // Back end: gain table, mixing and result output.
   cmm_back #(
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
      .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (head_cmd),
      .cmd_valid   (queue_not_empty),
      .cmd_pop     (queue_pop),
      .frame_clear (csr_wr),
      .nin_eff     (nin_eff),
      .nout_eff    (nout_eff),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/cmm_checker.sv
// ----------------------------------------------------------------------------
// Channel mix matrix checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "channel_mix_matrix_macros.svh"

module cmm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input cmm_pkg::cmm_result_type rsp_data
);
   import cmm_pkg::*;

   // A stalled result beat stays put.
   `CMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp held")

   // A clipped result sits exactly on one of the two bounds.
   `CMM_ASSERT_NOW(a_clip_bound, rsp_valid && rsp_data.clipped, (rsp_data.mixed_sample == SAMPLE_MAX) || (rsp_data.mixed_sample == SAMPLE_MIN), "clip bound")

   // A clipped result has already been counted.
   `CMM_ASSERT_NOW(a_clip_counted, rsp_valid && rsp_data.clipped, rsp_data.clip_total != '0, "clip count")

   // The clip count grows by at most one from one result beat to the next.
   `CMM_ASSERT_NEXT(a_clip_step, rsp_valid && !rsp_stall, !rsp_valid || (rsp_data.clip_total == $past(rsp_data.clip_total)) || (rsp_data.clip_total == $past(rsp_data.clip_total) + 32'd1), "clip step")

endmodule

bind channel_mix_matrix cmm_checker u_cmm_checker (.*);

`default_nettype wire
